/* rtl/aabb_pkg.sv */
// ----------------------------------------------------------------------------
// aabb_pkg
// Types and constants shared by the bounding box transform datapath.
// ----------------------------------------------------------------------------
`default_nettype none

package aabb_pkg;

    localparam int NUM_REGS   = 6;
    localparam int NUM_ROWS   = 3;
    localparam int NUM_AXES   = 3;
    localparam int NUM_STAGES = 4;
    localparam int REG_W      = 64;
    localparam int REG_IDX_W  = 3;
    localparam int COORD_W    = 32;
    localparam int PROD_W     = 2 * COORD_W;
    localparam int SUM_W      = PROD_W + 2;

    localparam logic [REG_IDX_W-1:0] REG_ROW0_COLS01 = 3'd0;
    localparam logic [REG_IDX_W-1:0] REG_ROW0_COLS23 = 3'd1;
    localparam logic [REG_IDX_W-1:0] REG_ROW1_COLS01 = 3'd2;
    localparam logic [REG_IDX_W-1:0] REG_ROW1_COLS23 = 3'd3;
    localparam logic [REG_IDX_W-1:0] REG_ROW2_COLS01 = 3'd4;
    localparam logic [REG_IDX_W-1:0] REG_ROW2_COLS23 = 3'd5;

    typedef struct packed {
        logic signed [COORD_W-1:0] local_min_x;
        logic signed [COORD_W-1:0] local_min_y;
        logic signed [COORD_W-1:0] local_min_z;
        logic signed [COORD_W-1:0] local_max_x;
        logic signed [COORD_W-1:0] local_max_y;
        logic signed [COORD_W-1:0] local_max_z;
    } in_beat_t;

    typedef struct packed {
        logic signed [COORD_W-1:0] world_min_x;
        logic signed [COORD_W-1:0] world_min_y;
        logic signed [COORD_W-1:0] world_min_z;
        logic signed [COORD_W-1:0] world_max_x;
        logic signed [COORD_W-1:0] world_max_y;
        logic signed [COORD_W-1:0] world_max_z;
    } out_beat_t;

    typedef struct packed {
        logic signed [COORD_W-1:0] c0;
        logic signed [COORD_W-1:0] c1;
        logic signed [COORD_W-1:0] c2;
        logic signed [COORD_W-1:0] trans;
    } coef_row_t;

    typedef coef_row_t [NUM_ROWS-1:0] coef_set_t;

    typedef logic [NUM_AXES-1:0][COORD_W-1:0] coord3_t;

    typedef struct packed {
        logic [NUM_STAGES-1:0] load;
    } stage_ctl_t;

endpackage

`default_nettype wire

/* rtl/affine_bounding_box_transform.sv */
// ----------------------------------------------------------------------------
// affine_bounding_box_transform
// Local box through a 3x4 affine matrix to the enclosing world box.
// Register stages, in order: multiply, min/max, sum, floor and clamp.
// Throughput: one box per cycle unless the output stalls; each stage holds its
// beat only while the stage after it is full and stalled.
// Reset: clears all stage valid bits and loads the identity matrix.
// ----------------------------------------------------------------------------
`default_nettype none

module affine_bounding_box_transform
    import aabb_pkg::*;
#(
    parameter int FRAC_BITS = 16
)
(
    input  wire logic                 clk,
    input  wire logic                 rst_n,
    input  wire logic                 in_valid,
    output logic                      in_stall,
    input  wire in_beat_t             in_data,
    output logic                      out_valid,
    input  wire logic                 out_stall,
    output out_beat_t                 out_data,
    input  wire logic                 cfg_wr_en,
    input  wire logic [REG_IDX_W-1:0] cfg_index,
    input  wire logic [REG_W-1:0]     cfg_data
);

    coef_set_t             coefs;
    stage_ctl_t            ctl;
    coord3_t               lo;
    coord3_t               hi;
    logic [NUM_STAGES-1:0] valid_reg;
    logic [NUM_STAGES-1:0] valid_next;
    logic [COORD_W-1:0]    wmin [NUM_ROWS];
    logic [COORD_W-1:0]    wmax [NUM_ROWS];

    aabb_cfg #(
        .FRAC_BITS (FRAC_BITS)
    ) u_cfg (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_wr_en (cfg_wr_en),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .coefs     (coefs)
    );

    // advance a stage when it is empty or the next stage advances
    always_comb
    begin
        ctl.load[NUM_STAGES-1] = !valid_reg[NUM_STAGES-1] || !out_stall;
        for (int k = NUM_STAGES - 2; k >= 0; k--)
            ctl.load[k] = !valid_reg[k] || ctl.load[k+1];
        valid_next = valid_reg;
        if (ctl.load[0])
            valid_next[0] = in_valid;
        for (int k = 1; k < NUM_STAGES; k++)
            if (ctl.load[k])
                valid_next[k] = valid_reg[k-1];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            valid_reg <= '0;
        else
            valid_reg <= valid_next;
    end

    assign in_stall  = !ctl.load[0];
    assign out_valid = valid_reg[NUM_STAGES-1];

    assign lo[0] = in_data.local_min_x;
    assign lo[1] = in_data.local_min_y;
    assign lo[2] = in_data.local_min_z;
    assign hi[0] = in_data.local_max_x;
    assign hi[1] = in_data.local_max_y;
    assign hi[2] = in_data.local_max_z;

    for (genvar r = 0; r < NUM_ROWS; r++)
    begin : g_row
        aabb_row #(
            .FRAC_BITS (FRAC_BITS)
        ) u_row (
            .clk       (clk),
            .ctl       (ctl),
            .coef      (coefs[r]),
            .lo        (lo),
            .hi        (hi),
            .world_min (wmin[r]),
            .world_max (wmax[r])
        );
    end

    assign out_data.world_min_x = wmin[0];
    assign out_data.world_min_y = wmin[1];
    assign out_data.world_min_z = wmin[2];
    assign out_data.world_max_x = wmax[0];
    assign out_data.world_max_y = wmax[1];
    assign out_data.world_max_z = wmax[2];

    a_min_le_max: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> (out_data.world_min_x <= out_data.world_max_x)
                   && (out_data.world_min_y <= out_data.world_max_y)
                   && (out_data.world_min_z <= out_data.world_max_z))
        else $error("world box min above max");

    a_stall_full: assert property (@(posedge clk) disable iff (!rst_n)
        in_stall |-> (&valid_reg) && out_stall)
        else $error("input stalled with a bubble in the pipeline");

    a_out_from_stage: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid) |-> $past(valid_reg[NUM_STAGES-2]))
        else $error("output beat without a beat in the sum stage");

endmodule

`default_nettype wire

/* rtl/aabb_cfg.sv */
// ----------------------------------------------------------------------------
// aabb_cfg
// Matrix register file: six 64-bit registers, two coefficients each.
// ----------------------------------------------------------------------------
`default_nettype none

module aabb_cfg
    import aabb_pkg::*;
#(
    parameter int FRAC_BITS = 16
)
(
    input  wire logic                 clk,
    input  wire logic                 rst_n,
    input  wire logic                 cfg_wr_en,
    input  wire logic [REG_IDX_W-1:0] cfg_index,
    input  wire logic [REG_W-1:0]     cfg_data,
    output coef_set_t                 coefs
);

    localparam logic [REG_W-1:0] ONE_FIXED = REG_W'(1) << FRAC_BITS;

    logic [REG_W-1:0] regs_reg [NUM_REGS];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            regs_reg[0] <= ONE_FIXED;
            regs_reg[1] <= '0;
            regs_reg[2] <= ONE_FIXED << COORD_W;
            regs_reg[3] <= '0;
            regs_reg[4] <= '0;
            regs_reg[5] <= ONE_FIXED;
        end
        else if (cfg_wr_en)
        begin
            unique case (cfg_index)
                REG_ROW0_COLS01: regs_reg[0] <= cfg_data;
                REG_ROW0_COLS23: regs_reg[1] <= cfg_data;
                REG_ROW1_COLS01: regs_reg[2] <= cfg_data;
                REG_ROW1_COLS23: regs_reg[3] <= cfg_data;
                REG_ROW2_COLS01: regs_reg[4] <= cfg_data;
                REG_ROW2_COLS23: regs_reg[5] <= cfg_data;
                default: ;
            endcase
        end
    end

    always_comb
    begin
        for (int r = 0; r < NUM_ROWS; r++)
        begin
            coefs[r].c0    = regs_reg[2*r][COORD_W-1:0];
            coefs[r].c1    = regs_reg[2*r][REG_W-1:COORD_W];
            coefs[r].c2    = regs_reg[2*r+1][COORD_W-1:0];
            coefs[r].trans = regs_reg[2*r+1][REG_W-1:COORD_W];
        end
    end

endmodule

`default_nettype wire

/* rtl/aabb_row.sv */
// ----------------------------------------------------------------------------
// aabb_row
// One output axis: multiply, min/max, sum with translation, floor and clamp.
// ----------------------------------------------------------------------------
`default_nettype none

module aabb_row
    import aabb_pkg::*;
#(
    parameter int FRAC_BITS = 16
)
(
    input  wire logic                 clk,
    input  wire stage_ctl_t           ctl,
    input  wire coef_row_t            coef,
    input  wire coord3_t              lo,
    input  wire coord3_t              hi,
    output logic signed [COORD_W-1:0] world_min,
    output logic signed [COORD_W-1:0] world_max
);

    logic signed [COORD_W-1:0] c [NUM_AXES];

    logic signed [PROD_W-1:0]  p_lo_reg   [NUM_AXES];
    logic signed [PROD_W-1:0]  p_hi_reg   [NUM_AXES];
    logic signed [PROD_W-1:0]  p_lo_next  [NUM_AXES];
    logic signed [PROD_W-1:0]  p_hi_next  [NUM_AXES];
    logic signed [PROD_W-1:0]  pmin_reg   [NUM_AXES];
    logic signed [PROD_W-1:0]  pmax_reg   [NUM_AXES];
    logic signed [PROD_W-1:0]  pmin_next  [NUM_AXES];
    logic signed [PROD_W-1:0]  pmax_next  [NUM_AXES];
    logic signed [SUM_W-1:0]   smin_reg;
    logic signed [SUM_W-1:0]   smax_reg;
    logic signed [SUM_W-1:0]   smin_next;
    logic signed [SUM_W-1:0]   smax_next;
    logic signed [SUM_W-1:0]   shmin;
    logic signed [SUM_W-1:0]   shmax;
    logic signed [SUM_W-1:0]   trans_ext;
    logic signed [COORD_W-1:0] wmin_reg;
    logic signed [COORD_W-1:0] wmax_reg;
    logic signed [COORD_W-1:0] wmin_next;
    logic signed [COORD_W-1:0] wmax_next;

    function automatic logic signed [COORD_W-1:0] clamp(input logic signed [SUM_W-1:0] v);
        logic signed [COORD_W-1:0] res;
        if (!v[SUM_W-1] && (|v[SUM_W-2:COORD_W-1]))
            res = {1'b0, {(COORD_W-1){1'b1}}};
        else if (v[SUM_W-1] && !(&v[SUM_W-2:COORD_W-1]))
            res = {1'b1, {(COORD_W-1){1'b0}}};
        else
            res = v[COORD_W-1:0];
        return res;
    endfunction

    assign c[0] = coef.c0;
    assign c[1] = coef.c1;
    assign c[2] = coef.c2;

    always_comb
    begin
        for (int a = 0; a < NUM_AXES; a++)
        begin
            p_lo_next[a] = $signed(lo[a]) * c[a];
            p_hi_next[a] = $signed(hi[a]) * c[a];
            if (p_lo_reg[a] < p_hi_reg[a])
            begin
                pmin_next[a] = p_lo_reg[a];
                pmax_next[a] = p_hi_reg[a];
            end
            else
            begin
                pmin_next[a] = p_hi_reg[a];
                pmax_next[a] = p_lo_reg[a];
            end
        end
    end

    assign trans_ext = SUM_W'(coef.trans) <<< FRAC_BITS;
    assign smin_next = SUM_W'(pmin_reg[0]) + SUM_W'(pmin_reg[1])
                     + SUM_W'(pmin_reg[2]) + trans_ext;
    assign smax_next = SUM_W'(pmax_reg[0]) + SUM_W'(pmax_reg[1])
                     + SUM_W'(pmax_reg[2]) + trans_ext;

    assign shmin     = smin_reg >>> FRAC_BITS;
    assign shmax     = smax_reg >>> FRAC_BITS;
    assign wmin_next = clamp(shmin);
    assign wmax_next = clamp(shmax);

    always_ff @(posedge clk)
    begin
        if (ctl.load[0])
        begin
            p_lo_reg <= p_lo_next;
            p_hi_reg <= p_hi_next;
        end
        if (ctl.load[1])
        begin
            pmin_reg <= pmin_next;
            pmax_reg <= pmax_next;
        end
        if (ctl.load[2])
        begin
            smin_reg <= smin_next;
            smax_reg <= smax_next;
        end
        if (ctl.load[3])
        begin
            wmin_reg <= wmin_next;
            wmax_reg <= wmax_next;
        end
    end

    assign world_min = wmin_reg;
    assign world_max = wmax_reg;

endmodule

`default_nettype wire

/* sim/tb_affine_bounding_box_transform.sv */
// ----------------------------------------------------------------------------
// tb_affine_bounding_box_transform
// Checks the box transform against an in-bench predictor. Local boxes are
// queued by the stimulus thread and offered by a clocked driver with random
// gaps; a clocked monitor stalls at random, holds off for long stretches a
// few times, and compares every world box field by field with the oldest
// prediction. The matrix is reloaded between phases while the block is idle.
// ----------------------------------------------------------------------------

module tb_affine_bounding_box_transform;

    import aabb_pkg::*;

    localparam int                   Q_FRAC        = 16;
    localparam longint               Q_ONE         = longint'(1) << Q_FRAC;
    localparam int                   PAYLOAD_W     = 6 * COORD_W;
    localparam int                   HOLD_CYCLES   = 300;
    localparam int                   HOLD_SPACING  = 500;
    localparam int                   STALL_LIMIT   = 3000;
    localparam int                   PHASE_BOXES   = 225;
    localparam int                   RANDOM_PHASES = 8;
    localparam logic [REG_IDX_W-1:0] REG_SPARE_6   = 3'd6;
    localparam logic [REG_IDX_W-1:0] REG_SPARE_7   = 3'd7;
    localparam logic [COORD_W-1:0]   Q_MIN         = 32'h8000_0000;
    localparam logic [COORD_W-1:0]   Q_MAX         = 32'h7FFF_FFFF;
    localparam logic [COORD_W-1:0]   Q_UNIT        = 32'h0001_0000;
    localparam logic [COORD_W-1:0]   Q_NEG_UNIT    = 32'hFFFF_0000;
    localparam logic [COORD_W-1:0]   Q_ZERO        = 32'h0000_0000;

    logic                 clk       = 1'b0;
    logic                 rst_n     = 1'b0;
    logic                 in_valid  = 1'b0;
    logic                 in_stall;
    in_beat_t             in_data   = '0;
    logic                 out_valid;
    logic                 out_stall = 1'b0;
    out_beat_t            out_data;
    logic                 cfg_wr_en = 1'b0;
    logic [REG_IDX_W-1:0] cfg_index = '0;
    logic [REG_W-1:0]     cfg_data  = '0;

    logic [REG_W-1:0] matrix_regs [NUM_REGS];
    in_beat_t         local_box_queue [$];
    out_beat_t        pending_world_boxes [$];

    int send_gap_pct   = 0;
    int recv_gap_pct   = 0;
    int send_gap       = 0;
    int recv_gap       = 0;
    int hold_left      = 0;
    int holds_done     = 0;
    int boxes_received = 0;
    int idle_cycles    = 0;
    int error_count    = 0;

    string field_names [6] = '{"world_min_x", "world_min_y", "world_min_z",
                               "world_max_x", "world_max_y", "world_max_z"};

    affine_bounding_box_transform uut (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .in_data   (in_data),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .out_data  (out_data),
        .cfg_wr_en (cfg_wr_en),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    always #5 clk = ~clk;

    function automatic logic [COORD_W-1:0] clamp_q(longint v);
        if (v > longint'(32'sh7FFF_FFFF))
            return Q_MAX;
        if (v < -longint'(64'sh8000_0000))
            return Q_MIN;
        return v[COORD_W-1:0];
    endfunction

    function automatic out_beat_t transform_box(in_beat_t b);
        longint    lo_c [3];
        longint    hi_c [3];
        longint    coef [3];
        longint    trans;
        longint    p_lo;
        longint    p_hi;
        longint    tmp;
        longint    lo_whole;
        longint    hi_whole;
        longint    lo_frac;
        longint    hi_frac;
        out_beat_t r;
        lo_c[0] = longint'(signed'(b.local_min_x));
        lo_c[1] = longint'(signed'(b.local_min_y));
        lo_c[2] = longint'(signed'(b.local_min_z));
        hi_c[0] = longint'(signed'(b.local_max_x));
        hi_c[1] = longint'(signed'(b.local_max_y));
        hi_c[2] = longint'(signed'(b.local_max_z));
        r = '0;
        for (int row = 0; row < NUM_ROWS; row++)
        begin
            coef[0] = longint'(signed'(matrix_regs[2*row][31:0]));
            coef[1] = longint'(signed'(matrix_regs[2*row][63:32]));
            coef[2] = longint'(signed'(matrix_regs[2*row+1][31:0]));
            trans   = longint'(signed'(matrix_regs[2*row+1][63:32]));
            lo_whole = 0;
            hi_whole = 0;
            lo_frac  = 0;
            hi_frac  = 0;
            for (int a = 0; a < NUM_AXES; a++)
            begin
                p_lo = coef[a] * lo_c[a];
                p_hi = coef[a] * hi_c[a];
                if (p_hi < p_lo)
                begin
                    tmp  = p_lo;
                    p_lo = p_hi;
                    p_hi = tmp;
                end
                lo_whole += p_lo >>> Q_FRAC;
                hi_whole += p_hi >>> Q_FRAC;
                lo_frac  += p_lo & (Q_ONE - 1);
                hi_frac  += p_hi & (Q_ONE - 1);
            end
            lo_whole += (lo_frac >>> Q_FRAC) + trans;
            hi_whole += (hi_frac >>> Q_FRAC) + trans;
            r[PAYLOAD_W-1-COORD_W*row -: COORD_W]       = clamp_q(lo_whole);
            r[PAYLOAD_W-1-COORD_W*(row+3) -: COORD_W]   = clamp_q(hi_whole);
        end
        return r;
    endfunction

    function automatic int draw_gap(int pct);
        int unsigned pick;
        if ($urandom_range(99) >= pct)
            return 0;
        pick = $urandom_range(99);
        if (pick < 85)
            return $urandom_range(3, 1);
        if (pick < 97)
            return $urandom_range(12, 4);
        return $urandom_range(60, 20);
    endfunction

    function automatic logic [COORD_W-1:0] pick_extreme();
        case ($urandom_range(5))
            0: return Q_MIN;
            1: return Q_MAX;
            2: return '0;
            3: return '1;
            4: return Q_UNIT;
            default: return Q_NEG_UNIT;
        endcase
    endfunction

    function automatic logic [COORD_W-1:0] rand_coord();
        int unsigned pick;
        pick = $urandom_range(99);
        if (pick < 60)
            return $urandom_range(32'h0080_0000) - 32'h0040_0000;
        if (pick < 85)
            return $urandom;
        return pick_extreme();
    endfunction

    function automatic logic [COORD_W-1:0] rand_coef();
        int unsigned pick;
        pick = $urandom_range(99);
        if (pick < 45)
            return $urandom_range(32'h0008_0000) - 32'h0004_0000;
        if (pick < 75)
            return $urandom;
        return pick_extreme();
    endfunction

    function automatic in_beat_t make_random_box();
        logic signed [COORD_W-1:0] lo [3];
        logic signed [COORD_W-1:0] hi [3];
        logic signed [COORD_W-1:0] tmp;
        logic                      ordered;
        in_beat_t                  b;
        ordered = $urandom_range(99) < 85;
        for (int a = 0; a < 3; a++)
        begin
            lo[a] = rand_coord();
            hi[a] = rand_coord();
            if (ordered && lo[a] > hi[a])
            begin
                tmp   = lo[a];
                lo[a] = hi[a];
                hi[a] = tmp;
            end
        end
        b.local_min_x = lo[0];
        b.local_min_y = lo[1];
        b.local_min_z = lo[2];
        b.local_max_x = hi[0];
        b.local_max_y = hi[1];
        b.local_max_z = hi[2];
        return b;
    endfunction

    task automatic flag_mismatch(string msg);
        $display("%0t: mismatch: %s", $realtime, msg);
        error_count++;
    endtask

    task automatic push_box(logic [COORD_W-1:0] min_x, logic [COORD_W-1:0] min_y,
                            logic [COORD_W-1:0] min_z, logic [COORD_W-1:0] max_x,
                            logic [COORD_W-1:0] max_y, logic [COORD_W-1:0] max_z);
        in_beat_t b;
        b = {min_x, min_y, min_z, max_x, max_y, max_z};
        local_box_queue = {local_box_queue, b};
    endtask

    task automatic write_matrix_reg(logic [REG_IDX_W-1:0] idx, logic [REG_W-1:0] value);
        @(posedge clk);
        cfg_wr_en <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= value;
        if (idx < NUM_REGS)
            matrix_regs[idx] = value;
        @(posedge clk);
        cfg_wr_en <= 1'b0;
    endtask

    task automatic load_matrix(logic [REG_W-1:0] m [NUM_REGS]);
        for (int i = 0; i < NUM_REGS; i++)
            write_matrix_reg(REG_IDX_W'(i), m[i]);
    endtask

    task automatic wait_idle();
        @(negedge clk);
        while (local_box_queue.size() != 0 || in_valid || pending_world_boxes.size() != 0)
            @(negedge clk);
    endtask

    // driver: offer queued boxes, hold a stalled beat
    always @(posedge clk)
    begin : driver_side
        logic fire;
        fire = in_valid && !in_stall;
        if (fire)
        begin
            pending_world_boxes = {pending_world_boxes, transform_box(in_data)};
            void'(local_box_queue.pop_front());
            send_gap = draw_gap(send_gap_pct);
        end
        if (in_valid && !fire)
        begin
        end
        else if (send_gap > 0)
        begin
            send_gap--;
            in_valid <= 1'b0;
        end
        else if (local_box_queue.size() > 0)
        begin
            in_valid <= 1'b1;
            in_data  <= local_box_queue[0];
        end
        else
            in_valid <= 1'b0;
    end

    // monitor: check each beat, then decide the next stall
    always @(posedge clk)
    begin : monitor_side
        logic      stall_next;
        out_beat_t want;
        if (out_valid && !out_stall)
        begin
            if (pending_world_boxes.size() == 0)
                flag_mismatch($sformatf("world box %h with none expected", out_data));
            else
            begin
                want = pending_world_boxes.pop_front();
                for (int k = 0; k < 6; k++)
                    if (out_data[PAYLOAD_W-1-COORD_W*k -: COORD_W]
                        !== want[PAYLOAD_W-1-COORD_W*k -: COORD_W])
                        flag_mismatch($sformatf("%s got %h want %h (beat %0d)",
                            field_names[k], out_data[PAYLOAD_W-1-COORD_W*k -: COORD_W],
                            want[PAYLOAD_W-1-COORD_W*k -: COORD_W], boxes_received));
            end
            boxes_received++;
        end
        if (hold_left > 0)
        begin
            hold_left--;
            stall_next = 1'b1;
        end
        else if (holds_done < 2 && boxes_received >= HOLD_SPACING * (holds_done + 1)
                 && local_box_queue.size() > 20)
        begin
            hold_left  = HOLD_CYCLES - 1;
            holds_done++;
            stall_next = 1'b1;
        end
        else if (recv_gap > 0)
        begin
            recv_gap--;
            stall_next = 1'b1;
        end
        else
        begin
            recv_gap   = draw_gap(recv_gap_pct);
            stall_next = recv_gap > 0;
            if (recv_gap > 0)
                recv_gap--;
        end
        out_stall <= stall_next;
    end

    always @(posedge clk)
    begin
        if ((in_valid && !in_stall) || (out_valid && !out_stall) || cfg_wr_en)
            idle_cycles = 0;
        else
            idle_cycles++;
        if (idle_cycles >= STALL_LIMIT)
        begin
            $display("TEST FAILED");
            $finish;
        end
    end

    initial
    begin : stimulus
        logic [REG_W-1:0] m [NUM_REGS];
        matrix_regs[REG_ROW0_COLS01] = 64'(Q_ONE);
        matrix_regs[REG_ROW0_COLS23] = '0;
        matrix_regs[REG_ROW1_COLS01] = 64'(Q_ONE) << 32;
        matrix_regs[REG_ROW1_COLS23] = '0;
        matrix_regs[REG_ROW2_COLS01] = '0;
        matrix_regs[REG_ROW2_COLS23] = 64'(Q_ONE);
        repeat (9) @(posedge clk);
        rst_n <= 1'b1;

        // identity after reset: extremes pass through, inverted boxes swap
        @(negedge clk);
        push_box('0, '0, '0, '0, '0, '0);
        push_box(Q_MIN, Q_MIN, Q_MIN, Q_MAX, Q_MAX, Q_MAX);
        push_box(Q_MAX, Q_MAX, Q_MAX, Q_MIN, Q_MIN, Q_MIN);
        push_box(Q_NEG_UNIT, '1, Q_MIN, Q_UNIT, 32'h0000_0001, '0);
        push_box(32'h0003_8000, 32'hFFF2_4000, 32'h0000_0001, 32'h0001_0000,
                 32'h0007_FFFF, '1);
        push_box(32'h5555_5555, 32'hAAAA_AAAA, 32'h1234_5678,
                 32'hAAAA_AAAA, 32'h5555_5555, 32'hEDCB_A988);
        wait_idle();

        // most negative coefficients, translations at the rails and zero: saturate
        load_matrix('{{Q_MIN, Q_MIN}, {Q_MAX, Q_MIN}, {Q_MIN, Q_MIN},
                      {Q_MIN, Q_MIN}, {Q_MIN, Q_MIN}, {Q_ZERO, Q_MIN}});
        write_matrix_reg(REG_SPARE_6, '1);
        write_matrix_reg(REG_SPARE_7, 64'h0123_4567_89AB_CDEF);
        @(negedge clk);
        push_box(Q_MIN, Q_MIN, Q_MIN, Q_MIN, Q_MIN, Q_MIN);
        push_box(Q_MAX, Q_MAX, Q_MAX, Q_MAX, Q_MAX, Q_MAX);
        push_box(Q_MIN, Q_MIN, Q_MIN, Q_MAX, Q_MAX, Q_MAX);
        push_box('1, '1, '1, 32'h0000_0001, 32'h0000_0001, 32'h0000_0001);
        push_box('0, '0, '0, '0, '0, '0);
        push_box(Q_UNIT, Q_NEG_UNIT, '0, Q_NEG_UNIT, Q_UNIT, '0);
        wait_idle();

        // largest positive coefficients
        load_matrix('{{Q_MAX, Q_MAX}, {Q_MIN, Q_MAX}, {Q_MAX, Q_MAX},
                      {Q_MAX, Q_MAX}, {Q_MAX, Q_MAX}, {Q_NEG_UNIT, Q_MAX}});
        @(negedge clk);
        push_box(Q_MIN, Q_MIN, Q_MIN, Q_MAX, Q_MAX, Q_MAX);
        push_box(Q_MAX, Q_MAX, Q_MAX, Q_MAX, Q_MAX, Q_MAX);
        push_box(Q_MIN, Q_MIN, Q_MIN, Q_MIN, Q_MIN, Q_MIN);
        push_box('1, '0, 32'h0000_0001, '0, '1, '1);
        push_box(32'h0000_0003, 32'hFFFF_FFFD, '0, 32'h0000_0005, 32'h0000_0002, '0);
        push_box(32'h0100_0000, 32'hFF00_0000, '0, 32'h00FF_0000, 32'h0001_0000, '1);
        wait_idle();

        for (int ph = 0; ph < RANDOM_PHASES; ph++)
        begin
            for (int i = 0; i < NUM_REGS; i++)
                m[i] = {rand_coef(), rand_coef()};
            load_matrix(m);
            if (ph % 3 == 1)
                write_matrix_reg(ph % 2 ? REG_SPARE_7 : REG_SPARE_6, {$urandom, $urandom});
            case (ph)
                0: begin send_gap_pct = 0;  recv_gap_pct = 0;  end
                1: begin send_gap_pct = 30; recv_gap_pct = 30; end
                2: begin send_gap_pct = 10; recv_gap_pct = 5;  end
                3: begin send_gap_pct = 20; recv_gap_pct = 60; end
                4: begin send_gap_pct = 50; recv_gap_pct = 50; end
                5: begin send_gap_pct = 5;  recv_gap_pct = 80; end
                6: begin send_gap_pct = 80; recv_gap_pct = 10; end
                default: begin send_gap_pct = 40; recv_gap_pct = 40; end
            endcase
            @(negedge clk);
            for (int i = 0; i < PHASE_BOXES; i++)
                local_box_queue = {local_box_queue, make_random_box()};
            wait_idle();
        end

        repeat (12) @(posedge clk);
        if (error_count == 0 && pending_world_boxes.size() == 0)
            $display("TEST PASSED");
        else
            $display("TEST FAILED");
        $finish;
    end

endmodule

/* sim.f */
rtl/aabb_pkg.sv
rtl/aabb_cfg.sv
rtl/aabb_row.sv
rtl/affine_bounding_box_transform.sv
sim/tb_affine_bounding_box_transform.sv
